@@ src/gsbr_pkg.sv @@
// gsbr_pkg: shared constants, codes and control structs for the gas sensor
// baseline/ratio block. Depends on nothing; used by gsbr_ctrl, gsbr_dp and
// the top level.
package gsbr_pkg;

  // Fixed field widths
  localparam int CODE_W   = 12;   // sample_code / held_code port width
  localparam int TIME_W   = 32;
  localparam int PRE_W    = 20;   // preheat_ms register
  localparam int TOL_W    = 7;    // tolerance_pct register
  localparam int CFG_IDX_W = 1;
  localparam int STAT_W   = 3;
  localparam int RATIO_W  = 27;

  // Internal arithmetic widths
  localparam int SUM_W    = 16;   // calibration sum, baseline sum, N*x
  localparam int TP_W     = 24;   // tol*sum and 100*dev
  localparam int NUM_W    = 30;   // |N*x - base| * 10000
  localparam int DCNT_W   = $clog2(NUM_W);

  localparam logic [NUM_W-1:0] RATIO_MAX = NUM_W'(67108863);
  localparam int BP_SCALE = 10000;
  localparam int PCT_SCALE = 100;

  // Opcodes
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_CAL   = 2'd1;
  localparam logic [1:0] OP_MEAS  = 2'd2;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
  localparam logic [STAT_W-1:0] ST_ERR     = 3'd1;
  localparam logic [STAT_W-1:0] ST_READ    = 3'd2;
  localparam logic [STAT_W-1:0] ST_CONT    = 3'd3;
  localparam logic [STAT_W-1:0] ST_IGNORED = 3'd4;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PREHEAT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOL     = 1'd1;

  // Controller to datapath
  typedef struct packed {
    logic              load;       // capture the accepted item
    logic              cal_start;
    logic              cal_abort;
    logic              cal_acc;    // fold sample into sum/min/max
    logic              chk_prep;   // register tolerance terms
    logic              cal_close;  // end calibration
    logic              cal_pass;   // take the sum as baseline
    logic              meas_take;  // update held code, register |N*x - base|
    logic              div_load;   // scale and start the divider
    logic              div_step;
    logic              out_load;
    logic [STAT_W-1:0] res_status;
    logic              res_zero;   // ratio field forced to zero
  } gsbr_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [1:0] op;
    logic       ok;
    logic       cal_active;
    logic       cal_full;
    logic       preheat_block;
    logic       base_zero;
    logic       tol_pass;
    logic       div_last;
  } gsbr_stat_t;

endpackage

@@ src/gsbr_ctrl.sv @@
// gsbr_ctrl: sequencing state machine for the gas sensor block. Decides the
// result status and steps the datapath. Depends on gsbr_pkg.
module gsbr_ctrl
  import gsbr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_ready,
  output logic       result_valid,
  input  logic       result_ready,
  input  gsbr_stat_t st,
  output gsbr_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_CAL_CHECK, S_CAL_CMP, S_SCALE, S_DIV, S_FINISH
  } state_t;

  state_t            state;
  logic [STAT_W-1:0] res_status;
  logic              res_zero;
  logic              out_free;

  assign item_ready = (state == S_IDLE) && !rst;
  assign out_free   = !result_valid || result_ready;

  // Commands decoded from state and datapath status
  always_comb begin
    cmd            = '0;
    cmd.res_status = res_status;
    cmd.res_zero   = res_zero;
    case (state)
      S_IDLE: begin
        cmd.load = item_valid && item_ready;
      end
      S_DECODE: begin
        case (st.op)
          OP_START: cmd.cal_start = 1'b1;
          OP_CAL: begin
            if (st.cal_active) begin
              cmd.cal_abort = !st.ok;
              cmd.cal_acc   = st.ok;
            end
          end
          OP_MEAS: begin
            cmd.meas_take = !st.preheat_block && st.ok;
          end
          default: ;
        endcase
      end
      S_CAL_CHECK: begin
        cmd.chk_prep = st.cal_full;
      end
      S_CAL_CMP: begin
        cmd.cal_close = 1'b1;
        cmd.cal_pass  = st.tol_pass;
      end
      S_SCALE: cmd.div_load = 1'b1;
      S_DIV:   cmd.div_step = 1'b1;
      S_FINISH: cmd.out_load = out_free;
      default: ;
    endcase
  end

  // State, result code and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      res_status   <= ST_IGNORED;
      res_zero     <= 1'b1;
      result_valid <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (item_valid) begin
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          res_zero <= 1'b1;
          state    <= S_FINISH;
          case (st.op)
            OP_START: res_status <= ST_CONT;
            OP_CAL: begin
              if (!st.cal_active) begin
                res_status <= ST_IGNORED;
              end else if (!st.ok) begin
                res_status <= ST_READ;
              end else begin
                state <= S_CAL_CHECK;
              end
            end
            OP_MEAS: begin
              if (st.preheat_block) begin
                res_status <= ST_ERR;
              end else if (!st.ok) begin
                res_status <= ST_READ;
              end else begin
                res_status <= ST_OK;
                if (!st.base_zero) begin
                  res_zero <= 1'b0;
                  state    <= S_SCALE;
                end
              end
            end
            default: res_status <= ST_IGNORED;
          endcase
        end
        S_CAL_CHECK: begin
          if (st.cal_full) begin
            state <= S_CAL_CMP;
          end else begin
            res_status <= ST_CONT;
            state      <= S_FINISH;
          end
        end
        S_CAL_CMP: begin
          res_status <= st.tol_pass ? ST_OK : ST_ERR;
          state      <= S_FINISH;
        end
        S_SCALE: state <= S_DIV;
        S_DIV: begin
          if (st.div_last) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ src/gsbr_dp.sv @@
// gsbr_dp: datapath of the gas sensor block: config registers, calibration
// accumulators, tolerance check, restoring divider and result register.
// Depends on gsbr_pkg.
module gsbr_dp
  import gsbr_pkg::*;
#(
  parameter int CAL_SAMPLES = 10,
  parameter int CODE_BITS   = 12
)(
  input  logic                      clk,
  input  logic                      rst,
  input  gsbr_cmd_t                 cmd,
  output gsbr_stat_t                st,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [PRE_W-1:0]          cfg_data,
  input  logic [1:0]                opcode,
  input  logic [CODE_W-1:0]         sample_code,
  input  logic                      read_ok,
  input  logic [TIME_W-1:0]         now_ms,
  output logic [STAT_W-1:0]         status,
  output logic signed [RATIO_W-1:0] ratio_bp,
  output logic [CODE_W-1:0]         held_code,
  output logic [TIME_W-1:0]         time_out_ms
);

  localparam int CNT_W = $clog2(CAL_SAMPLES + 1);
  localparam logic [CODE_BITS-1:0] CODE_ONES = '1;

  // Captured item
  logic [1:0]           op_q;
  logic [CODE_BITS-1:0] x_q;
  logic                 ok_q;
  logic [TIME_W-1:0]    now_q;

  // Configuration
  logic [PRE_W-1:0] preheat_ms;
  logic [TOL_W-1:0] tolerance_pct;

  // Sensor state
  logic                 warmed;
  logic [TIME_W-1:0]    warm_start_ms;
  logic [SUM_W-1:0]     baseline_sum;
  logic [CODE_BITS-1:0] last_code;
  logic                 cal_active;
  logic [CNT_W-1:0]     cal_count;
  logic [SUM_W-1:0]     cal_sum;
  logic [CODE_BITS-1:0] cal_min;
  logic [CODE_BITS-1:0] cal_max;

  // Tolerance terms
  logic [TP_W-1:0]  tol_prod;
  logic [SUM_W-1:0] dev_min;
  logic [SUM_W-1:0] dev_max;

  // Ratio and divider
  logic             neg;
  logic [SUM_W-1:0] mag;
  logic [NUM_W-1:0] quo;
  logic [SUM_W-1:0] rem;
  logic [DCNT_W-1:0] div_cnt;

  logic [SUM_W-1:0]  nx_min, nx_max, nx_x;
  logic [TIME_W-1:0] elapsed;
  logic [SUM_W:0]    rem_sh;
  logic              rem_ge;
  logic [SUM_W:0]    rem_sub;
  logic [RATIO_W-1:0] ratio_val;

  // Scaled samples: N*x
  assign nx_min = SUM_W'(CAL_SAMPLES) * SUM_W'(cal_min);
  assign nx_max = SUM_W'(CAL_SAMPLES) * SUM_W'(cal_max);
  assign nx_x   = SUM_W'(CAL_SAMPLES) * SUM_W'(x_q);

  assign elapsed = now_q - warm_start_ms;

  // Status toward the controller
  always_comb begin
    st.op            = op_q;
    st.ok            = ok_q;
    st.cal_active    = cal_active;
    st.cal_full      = (cal_count >= CNT_W'(CAL_SAMPLES));
    st.preheat_block = !warmed && (warm_start_ms != '0) &&
                       (elapsed < TIME_W'(preheat_ms));
    st.base_zero     = (baseline_sum == '0);
    st.tol_pass      = (cal_sum == '0) ||
                       ((TP_W'(dev_min) * TP_W'(PCT_SCALE) <= tol_prod) &&
                        (TP_W'(dev_max) * TP_W'(PCT_SCALE) <= tol_prod));
    st.div_last      = (div_cnt == DCNT_W'(NUM_W - 1));
  end

  // Divider step: one quotient bit per cycle
  assign rem_sh  = {rem, quo[NUM_W-1]};
  assign rem_ge  = (rem_sh >= (SUM_W+1)'(baseline_sum));
  assign rem_sub = rem_sh - (SUM_W+1)'(baseline_sum);

  // Signed, saturated ratio
  always_comb begin
    if (cmd.res_zero) begin
      ratio_val = '0;
    end else if (neg) begin
      ratio_val = RATIO_W'(0) - RATIO_W'(quo);
    end else if (quo > RATIO_MAX) begin
      ratio_val = RATIO_W'(RATIO_MAX);
    end else begin
      ratio_val = RATIO_W'(quo);
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      preheat_ms    <= PRE_W'(60000);
      tolerance_pct <= TOL_W'(10);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PREHEAT: preheat_ms    <= cfg_data;
        CFG_TOL:     tolerance_pct <= cfg_data[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // Sensor and calibration state
  always_ff @(posedge clk) begin
    if (rst) begin
      warmed        <= 1'b0;
      warm_start_ms <= '0;
      baseline_sum  <= '0;
      last_code     <= '0;
      cal_active    <= 1'b0;
      cal_count     <= '0;
      cal_sum       <= '0;
      cal_min       <= CODE_ONES;
      cal_max       <= '0;
    end else begin
      if (cmd.cal_start) begin
        warmed        <= 1'b0;
        warm_start_ms <= now_q;
        cal_active    <= 1'b1;
        cal_count     <= '0;
        cal_sum       <= '0;
        cal_min       <= CODE_ONES;
        cal_max       <= '0;
      end
      if (cmd.cal_abort) begin
        cal_active <= 1'b0;
      end
      if (cmd.cal_acc) begin
        cal_sum   <= cal_sum + SUM_W'(x_q);
        cal_count <= cal_count + CNT_W'(1);
        if (x_q < cal_min) cal_min <= x_q;
        if (x_q > cal_max) cal_max <= x_q;
      end
      if (cmd.cal_close) begin
        cal_active <= 1'b0;
        cal_count  <= '0;
      end
      if (cmd.cal_pass) begin
        baseline_sum <= cal_sum;
        warmed       <= 1'b1;
      end
      if (cmd.meas_take) begin
        last_code <= x_q;
      end
    end
  end

  // Item capture, tolerance terms, divider and result payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q  <= opcode;
      x_q   <= sample_code[CODE_BITS-1:0];
      ok_q  <= read_ok;
      now_q <= now_ms;
    end
    if (cmd.chk_prep) begin
      tol_prod <= TP_W'(tolerance_pct) * TP_W'(cal_sum);
      dev_min  <= (nx_min >= cal_sum) ? nx_min - cal_sum : cal_sum - nx_min;
      dev_max  <= (nx_max >= cal_sum) ? nx_max - cal_sum : cal_sum - nx_max;
    end
    if (cmd.meas_take) begin
      neg <= (nx_x < baseline_sum);
      mag <= (nx_x >= baseline_sum) ? nx_x - baseline_sum : baseline_sum - nx_x;
    end
    if (cmd.div_load) begin
      quo     <= NUM_W'(mag) * NUM_W'(BP_SCALE);
      rem     <= '0;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      quo     <= {quo[NUM_W-2:0], rem_ge};
      rem     <= rem_ge ? rem_sub[SUM_W-1:0] : rem_sh[SUM_W-1:0];
      div_cnt <= div_cnt + DCNT_W'(1);
    end
    if (cmd.out_load) begin
      status      <= cmd.res_status;
      ratio_bp    <= ratio_val;
      held_code   <= CODE_W'(last_code);
      time_out_ms <= now_q;
    end
  end

endmodule

@@ src/gas_sensor_baseline_ratio.sv @@
// Gas sensor baseline/ratio front end: calibration and ratio on raw codes.
// Start, ignored, rejected and zero-baseline items pass decode and finish; a
// calibration sample adds the fill check, the last sample also the tolerance
// compare, a measurement the scale step and the divider (one quotient bit per
// cycle). One item in flight, held in finish by any result-side stall.
// Synchronous active-high reset: config to defaults, no calibration, no baseline.
module gas_sensor_baseline_ratio
  import gsbr_pkg::*;
#(
  parameter int CAL_SAMPLES = 10,
  parameter int CODE_BITS   = 12
)(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [PRE_W-1:0]          cfg_data,
  input  logic                      item_valid,
  output logic                      item_ready,
  input  logic [1:0]                opcode,
  input  logic [CODE_W-1:0]         sample_code,
  input  logic                      read_ok,
  input  logic [TIME_W-1:0]         now_ms,
  output logic                      result_valid,
  input  logic                      result_ready,
  output logic [STAT_W-1:0]         status,
  output logic signed [RATIO_W-1:0] ratio_bp,
  output logic [CODE_W-1:0]         held_code,
  output logic [TIME_W-1:0]         time_out_ms
);

  gsbr_cmd_t  cmd;
  gsbr_stat_t st;

  // Register writes are taken whenever reset is released
  assign cfg_ready = !rst;

  gsbr_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .st           (st),
    .cmd          (cmd)
  );

  gsbr_dp #(
    .CAL_SAMPLES (CAL_SAMPLES),
    .CODE_BITS   (CODE_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .st          (st),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .opcode      (opcode),
    .sample_code (sample_code),
    .read_ok     (read_ok),
    .now_ms      (now_ms),
    .status      (status),
    .ratio_bp    (ratio_bp),
    .held_code   (held_code),
    .time_out_ms (time_out_ms)
  );

endmodule
